// ===== hdl/slru_pkg.sv =====
// ----------------------------------------------------------------------------
// slru_pkg: shared types and constants of the LRU cache simulator
// Line entry, scan status, result and configuration structures, plus codes.
// ----------------------------------------------------------------------------
package slru_pkg;

  localparam int TAG_W       = 47;
  localparam int AGE_W       = 32;
  localparam int OUT_CNT_W   = 32;
  // Way indexes cover up to sixteen ways.
  localparam int WAY_IDX_W   = 4;
  localparam int OUT_FIELDS_W = 2 + 3 * OUT_CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_FETCH  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_WAYS       = 2'd1;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

  typedef struct packed {
    logic [2:0] set_bits;
    logic [3:0] ways_in_use;
    logic [4:0] block_bits;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } ent_t;

  typedef struct packed {
    logic                 hit;
    logic                 inv_found;
    logic [WAY_IDX_W-1:0] inv_way;
    logic [AGE_W-1:0]     best_age;
    logic [WAY_IDX_W-1:0] best_way;
  } scan_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted;
    logic [OUT_CNT_W-1:0] total_hits;
    logic [OUT_CNT_W-1:0] total_misses;
    logic [OUT_CNT_W-1:0] total_evictions;
    logic                 last_of_run;
  } res_t;

endpackage

// ===== hdl/slru_way_eval.sv =====
// ----------------------------------------------------------------------------
// slru_way_eval: per-way evaluation unit
// Ages one line, checks its tag and folds it into the running scan status.
// ----------------------------------------------------------------------------
module slru_way_eval (
  input  slru_pkg::ent_t                       ent,
  input  logic [slru_pkg::TAG_W-1:0]           tag,
  input  logic [slru_pkg::WAY_IDX_W-1:0]       way,
  input  slru_pkg::scan_t                      st_in,
  output slru_pkg::scan_t                      st_out,
  output logic [slru_pkg::AGE_W-1:0]           age_out
);

  logic [slru_pkg::AGE_W-1:0] aged;
  logic                       match;

  always_comb begin
    aged   = (ent.age == '1) ? ent.age : ent.age + 1'b1;
    match  = ent.valid && (ent.tag == tag);
    st_out = st_in;
    // Only the first matching way is refreshed; later matches just age.
    age_out = (match && !st_in.hit) ? '0 : aged;
    if (match) begin
      st_out.hit = 1'b1;
    end
    if (!ent.valid && !st_in.inv_found) begin
      st_out.inv_found = 1'b1;
      st_out.inv_way   = way;
    end
    // Way zero seeds the search; a strictly larger age wins, so ties keep the lower way.
    if ((way == '0) || (aged > st_in.best_age)) begin
      st_out.best_age = aged;
      st_out.best_way = way;
    end
  end

endmodule

// ===== hdl/slru_engine.sv =====
// ----------------------------------------------------------------------------
// slru_engine: access sequencer with line memory
// Clears the store, then walks the ways of a set one per cycle through the
// shared evaluation unit, fills or replaces a line and emits one result per
// access into an output register.
// ----------------------------------------------------------------------------
module slru_engine #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 48,
  parameter int COUNT_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slru_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  slru_pkg::cmd_t        in_command,
  input  logic [ADDR_BITS-1:0]  in_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output slru_pkg::res_t        out_res
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W = MAX_SET_BITS + WAY_W;
  localparam int DEPTH  = 2 ** LINE_W;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FILL,
    ST_EMIT
  } state_t;

  state_t                              state_r;
  logic [LINE_W-1:0]                   clr_r;
  logic [ADDR_BITS-1:0]                addr_r;
  logic                                two_r;
  logic [slru_pkg::TAG_W-1:0]          tag_r;
  logic [MAX_SET_BITS-1:0]             set_r;
  logic [WCNT_W-1:0]                   rd_way_r;
  logic                                pend_r;
  logic [slru_pkg::WAY_IDX_W-1:0]      pend_way_r;
  slru_pkg::scan_t                     scan_r;
  logic [COUNT_BITS-1:0]               hit_cnt_r;
  logic [COUNT_BITS-1:0]               miss_cnt_r;
  logic [COUNT_BITS-1:0]               evict_cnt_r;
  logic                                acc_hit_r;
  logic                                acc_ev_r;
  logic                                out_valid_r;
  slru_pkg::res_t                      out_r;

  slru_pkg::ent_t                      mem [DEPTH];
  slru_pkg::ent_t                      rd_q;

  logic [WCNT_W-1:0]                   nw;
  logic [3:0]                          sb;
  logic [4:0]                          bb;
  logic [MAX_SET_BITS-1:0]             set_mask;
  logic [63:0]                         sh_b;
  logic [63:0]                         sh_t;
  logic [slru_pkg::TAG_W-1:0]          tag_nxt;
  logic [MAX_SET_BITS-1:0]             set_nxt;
  logic                                issue;
  logic                                emit_go;
  logic [LINE_W-1:0]                   rd_addr;
  slru_pkg::scan_t                     scan_nxt;
  slru_pkg::scan_t                     scan_fin;
  logic [slru_pkg::AGE_W-1:0]          age_upd;
  logic [slru_pkg::WAY_IDX_W-1:0]      victim;
  logic                                we;
  logic [LINE_W-1:0]                   waddr;
  slru_pkg::ent_t                      wdata;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [slru_pkg::OUT_CNT_W-1:0] low_cnt(input logic [COUNT_BITS-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return e[slru_pkg::OUT_CNT_W-1:0];
  endfunction

  // Effective split of the address under the current configuration.
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      nw = WCNT_W'(1);
    end else if (32'(cfg.ways_in_use) > MAX_WAYS) begin
      nw = WCNT_W'(MAX_WAYS);
    end else begin
      nw = WCNT_W'(cfg.ways_in_use);
    end
    if (32'(cfg.set_bits) > MAX_SET_BITS) begin
      sb = 4'(MAX_SET_BITS);
    end else begin
      sb = 4'(cfg.set_bits);
    end
    bb = (cfg.block_bits == '0) ? 5'd1 : cfg.block_bits;
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_mask[i] = (4'(i) < sb);
    end
    sh_b    = 64'(addr_r) >> bb;
    sh_t    = sh_b >> sb;
    tag_nxt = sh_t[slru_pkg::TAG_W-1:0];
    set_nxt = sh_b[MAX_SET_BITS-1:0] & set_mask;
  end

  assign issue    = (state_r == ST_SCAN) && (rd_way_r < nw);
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign rd_addr  = {set_r, WAY_W'(rd_way_r)};
  assign scan_fin = pend_r ? scan_nxt : scan_r;
  assign victim   = scan_r.inv_found ? scan_r.inv_way : scan_r.best_way;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  slru_way_eval u_eval (
    .ent     (rd_q),
    .tag     (tag_r),
    .way     (pend_way_r),
    .st_in   (scan_r),
    .st_out  (scan_nxt),
    .age_out (age_upd)
  );

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
      end
      ST_SCAN: begin
        we          = pend_r;
        waddr       = {set_r, WAY_W'(pend_way_r)};
        wdata.valid = rd_q.valid;
        wdata.tag   = rd_q.tag;
        wdata.age   = age_upd;
      end
      ST_FILL: begin
        we          = 1'b1;
        waddr       = {set_r, WAY_W'(victim)};
        wdata.valid = 1'b1;
        wdata.tag   = tag_r;
        wdata.age   = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      two_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      pend_r     <= issue;
      pend_way_r <= slru_pkg::WAY_IDX_W'(rd_way_r);
      if (pend_r) begin
        scan_r <= scan_nxt;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            addr_r <= in_address;
            two_r  <= (in_command == slru_pkg::CMD_MODIFY);
            if (in_command != slru_pkg::CMD_FETCH) begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          tag_r    <= tag_nxt;
          set_r    <= set_nxt;
          rd_way_r <= '0;
          scan_r   <= '0;
          state_r  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (issue) begin
            rd_way_r <= rd_way_r + 1'b1;
          end else if (scan_fin.hit) begin
            // The last way is evaluated on this edge, so decide from its status.
            hit_cnt_r <= sat_inc(hit_cnt_r);
            acc_hit_r <= 1'b1;
            acc_ev_r  <= 1'b0;
            state_r   <= ST_EMIT;
          end else begin
            state_r <= ST_FILL;
          end
        end
        ST_FILL: begin
          miss_cnt_r <= sat_inc(miss_cnt_r);
          if (!scan_r.inv_found) begin
            evict_cnt_r <= sat_inc(evict_cnt_r);
          end
          acc_hit_r <= 1'b0;
          acc_ev_r  <= !scan_r.inv_found;
          state_r   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_r.hit             <= acc_hit_r;
            out_r.evicted         <= acc_ev_r;
            out_r.total_hits      <= low_cnt(hit_cnt_r);
            out_r.total_misses    <= low_cnt(miss_cnt_r);
            out_r.total_evictions <= low_cnt(evict_cnt_r);
            out_r.last_of_run     <= !two_r;
            if (two_r) begin
              two_r   <= 1'b0;
              state_r <= ST_PREP;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: set-associative LRU cache hit/miss simulator
// Trace beats enter on in_* (command and byte address); one result beat per
// cache access leaves on out_*: a load or store gives one beat, a modify
// two (tlast on the second), an instruction fetch none. Three registers on
// the APB port set the set-index bits, ways in use and block-offset bits.
// Each access runs a prep step, walks the ways of its set through one
// evaluation unit, one way per cycle, fills a line on a miss and then
// loads the output register; a modify costs two accesses. in_tready is
// low while an item is in work. The output register lets the next item
// be accepted while a result waits; a stalled receiver holds the second
// access of a modify. After reset the line store is cleared, one line per
// cycle, all 2**(MAX_SET_BITS + way index bits) lines (512 by default),
// with in_tready low. Totals and ages saturate.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 48,
  parameter int COUNT_BITS   = 32,
  localparam int IN_TDATA_W  = ((2 + ADDR_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // command [1:0], address [ADDR_BITS+1:2], zero fill above
  input  logic [IN_TDATA_W-1:0]              in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit [0], evicted [1], total_hits [33:2], total_misses [65:34],
  // total_evictions [97:66], zero fill above
  output logic [slru_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  slru_pkg::cfg_t cfg_r;
  slru_pkg::res_t res;
  logic           cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_bits    <= slru_pkg::SET_BITS_RST;
      cfg_r.ways_in_use <= slru_pkg::WAYS_RST;
      cfg_r.block_bits  <= slru_pkg::BLOCK_BITS_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        slru_pkg::REG_SET_BITS:   cfg_r.set_bits    <= pwdata[2:0];
        slru_pkg::REG_WAYS:       cfg_r.ways_in_use <= pwdata[3:0];
        slru_pkg::REG_BLOCK_BITS: cfg_r.block_bits  <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      slru_pkg::REG_SET_BITS:   prdata = 32'(cfg_r.set_bits);
      slru_pkg::REG_WAYS:       prdata = 32'(cfg_r.ways_in_use);
      slru_pkg::REG_BLOCK_BITS: prdata = 32'(cfg_r.block_bits);
      default:                  prdata = '0;
    endcase
  end

  slru_engine #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_BITS    (ADDR_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_command (slru_pkg::cmd_t'(in_tdata[1:0])),
    .in_address (in_tdata[ADDR_BITS+1:2]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {{(slru_pkg::OUT_TDATA_W - slru_pkg::OUT_FIELDS_W){1'b0}},
                      res.total_evictions, res.total_misses, res.total_hits,
                      res.evicted, res.hit};
  assign out_tlast = res.last_of_run;

`ifndef SYNTHESIS
  // A fetch makes no access, so the block is ready again on the next cycle.
  a_fetch_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == slru_pkg::CMD_FETCH) |=> in_tready)
    else $error("block not ready after an instruction fetch");

  // Any real access keeps the block busy for its scan.
  a_access_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] != slru_pkg::CMD_FETCH) |=> !in_tready)
    else $error("block ready in the cycle after accepting an access");

  // Reset starts the clearing pass with no item accepted and no result shown.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block active right after reset");

  // A hit never replaces a line.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("result flags both hit and eviction");
`endif

endmodule
